// File: sv/mexp_pkg.sv
// Shared types for the modular exponentiation block.
// No dependencies; imported by mexp_mulmod and modular_exponentiation.
package mexp_pkg;

    // Status of the serial modular multiplier, seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

// File: sv/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: (a * b) mod m, one bit of a per cycle.
// Depends on mexp_pkg (t_mm_status).
module mexp_mulmod #(
    parameter int W = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_a,
    input  logic [W-1:0]          i_b,      // must not exceed i_m
    input  logic [W-1:0]          i_m,
    output logic [W-1:0]          o_result,
    output mexp_pkg::t_mm_status  o_status
);
    import mexp_pkg::*;

    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_m;
    logic [W-1:0]  r_acc;

    logic [W+1:0]  t_sum;
    logic [W+2:0]  t_d1;
    logic [W+2:0]  t_d2;
    logic [W-1:0]  n_acc;

    // One step: acc = 2*acc + a_bit*b, then bring back below m (sum < 3m)
    always_comb begin
        t_sum = {1'b0, r_acc, 1'b0} + {2'b00, (r_a[W-1] ? r_b : {W{1'b0}})};
        t_d1  = {1'b0, t_sum} - {3'b000, r_m};
        t_d2  = {1'b0, t_sum} - {2'b00, r_m, 1'b0};
        if (!t_d2[W+2]) begin
            n_acc = t_d2[W-1:0];
        end else if (!t_d1[W+2]) begin
            n_acc = t_d1[W-1:0];
        end else begin
            n_acc = t_sum[W-1:0];
        end
    end

    // Control: load on start, then W steps, done pulses after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: multiplier shifts out MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_result      = r_acc;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// File: sv/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply sequencer around one serial multiplier.
// Depends on mexp_pkg and mexp_mulmod.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   base, exponent, modulus
//   m_axis   out  m_axis_tvalid/m_axis_tready   power_result
//
// The serial multiplier forms each modular product one multiplier bit per cycle.
// A request costs the base reduction, then per exponent bit one decision state,
// a square for every bit below the top one and a multiply for every set bit.
// Zero exponent or zero modulus skips the multiplier. Reset is synchronous,
// active low, and empties the block. A new request is taken while a finished
// result still waits in the output register; a stalled output holds its beat.
module modular_exponentiation #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // fields from bit 0: base, exponent, modulus, zero pad
    input  logic [((3*OPERAND_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // fields from bit 0: power_result, zero pad
    output logic [((OPERAND_BITS+7)/8)*8-1:0]     m_axis_tdata
);
    import mexp_pkg::*;

    localparam int W    = OPERAND_BITS;
    localparam int OUTW = ((W + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SQR  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]   r_state;
    logic [2:0]   n_state;
    logic [W-1:0] r_e;
    logic [W-1:0] r_m;
    logic [W-1:0] r_base;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_res;
    logic         r_out_valid;
    logic [W-1:0] r_out_data;

    logic [W-1:0] in_base;
    logic [W-1:0] in_exp;
    logic [W-1:0] in_mod;
    logic         accept;

    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic [W-1:0] mm_m;
    logic [W-1:0] mm_result;
    t_mm_status   mm_sts;

    // Input beat unpacking
    assign in_base       = s_axis_tdata[W-1:0];
    assign in_exp        = s_axis_tdata[2*W-1:W];
    assign in_mod        = s_axis_tdata[3*W-1:2*W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Multiplier operand selection and start
    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_base;
        mm_b     = r_base;
        mm_m     = r_m;
        n_state  = r_state;
        unique case (r_state)
            ST_IDLE: begin
                mm_a = in_base;
                mm_b = W'(1);
                mm_m = in_mod;
                if (accept) begin
                    if (in_exp == '0 || in_mod == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        mm_start = 1'b1;
                        n_state  = ST_RED;
                    end
                end
            end
            ST_RED: begin
                if (mm_sts.done) n_state = ST_DEC;
            end
            ST_DEC: begin
                mm_start = 1'b1;
                if (r_e[0]) begin
                    mm_a    = r_acc;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_SQR;
                end
            end
            ST_MUL: begin
                if (mm_sts.done) begin
                    if (r_e[W-1:1] == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        mm_start = 1'b1;
                        n_state  = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (mm_sts.done) n_state = ST_DEC;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Exponent, base and accumulator registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e   <= in_exp;
            r_m   <= in_mod;
            r_acc <= W'(1);
            r_res <= (in_exp == '0) ? W'(1) : '0;
        end
        if (mm_sts.done) begin
            if (r_state == ST_RED) begin
                r_base <= mm_result;
            end
            if (r_state == ST_MUL) begin
                r_acc <= mm_result;
                r_res <= mm_result;
            end
            if (r_state == ST_SQR) begin
                r_base <= mm_result;
                r_e    <= {1'b0, r_e[W-1:1]};
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUTW'(r_out_data);

    mexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_m      (mm_m),
        .o_result (mm_result),
        .o_status (mm_sts)
    );

`ifndef SYNTHESIS
    // The multiplier is never restarted while it still works on a product
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_sts.busy |-> !mm_start)
        else $error("multiplier started while busy");

    // A done pulse only follows a busy multiplier
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_sts.done |-> $past(mm_sts.busy))
        else $error("multiplier done without work");

    // Requests are taken only while no product is in flight
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !mm_sts.busy)
        else $error("input ready while multiplier busy");

    // A finished result always reaches the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("finished result not presented");
`endif

endmodule

// File: tb/sv/modexp_checker.sv
// Checker for modular_exponentiation: watches the request and result streams,
// predicts base^exponent mod modulus per request and compares in order.
// Self-contained; instantiated beside the block by modular_exponentiation_tb.
module modexp_checker #(
    parameter int OP_BITS = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_tvalid,
    input  logic                             i_req_tready,
    // fields from bit 0: base, exponent, modulus, zero pad
    input  logic [((3*OP_BITS+7)/8)*8-1:0]   i_req_tdata,
    input  logic                             i_res_tvalid,
    input  logic                             i_res_tready,
    // fields from bit 0: power_result, zero pad
    input  logic [((OP_BITS+7)/8)*8-1:0]     i_res_tdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [OP_BITS-1:0] t_operand;

    // expected powers, oldest request first
    t_operand expected_powers[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // right-to-left square and multiply, each product exact and reduced at once
    function automatic t_operand predict_power(t_operand base, t_operand exponent,
                                               t_operand modulus);
        logic [63:0] run_base;
        logic [63:0] run_mod;
        logic [63:0] acc;
        t_operand    bits_left;
        run_base  = 64'(base);
        run_mod   = 64'(modulus);
        bits_left = exponent;
        acc       = 64'd1;
        // zero modulus: no division, a nonzero exponent gives 0
        if (bits_left != '0 && run_mod == 64'd0) begin
            acc = 64'd0;
        end else begin
            while (bits_left != '0) begin
                if (bits_left[0]) begin
                    acc = (acc * run_base) % run_mod;
                end
                run_base  = (run_base * run_base) % run_mod;
                bits_left = bits_left >> 1;
            end
        end
        return t_operand'(acc);
    endfunction

    task automatic report_failure(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    // one request beat in, one result beat out, compared in order
    always @(posedge i_clk) begin
        t_operand want;
        t_operand got;
        if (!i_rst_n) begin
            expected_powers.delete();
        end else begin
            if (i_req_tvalid && i_req_tready) begin
                expected_powers.push_back(predict_power(
                    i_req_tdata[OP_BITS-1:0],
                    i_req_tdata[2*OP_BITS-1:OP_BITS],
                    i_req_tdata[3*OP_BITS-1:2*OP_BITS]));
            end
            if (i_res_tvalid && i_res_tready) begin
                got = i_res_tdata[OP_BITS-1:0];
                if (expected_powers.size() == 0) begin
                    report_failure($sformatf("result beat 0x%h with no request pending", got));
                end else begin
                    want = expected_powers.pop_front();
                    if (got !== want) begin
                        report_failure($sformatf("power_result 0x%h, expected 0x%h",
                                                 got, want));
                    end
                end
            end
        end
        o_pending = expected_powers.size();
    end

endmodule

// File: tb/sv/modular_exponentiation_tb.sv
// Testbench top for modular_exponentiation: drives requests with random gaps and
// result stalls, and gives the verdict. Depends on modexp_checker and the block.
module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPERAND_BITS   = 31;
    localparam int REQ_W          = ((3*OPERAND_BITS+7)/8)*8;
    localparam int RES_W          = ((OPERAND_BITS+7)/8)*8;
    localparam int RANDOM_ITEMS   = 270;
    // allow for the worst request plus long gaps and stalls around it
    localparam int QUIET_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 2200;

    typedef logic [OPERAND_BITS-1:0] t_operand;
    localparam t_operand OPERAND_MAX = '1;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [REQ_W-1:0] s_axis_tdata;   // base, exponent, modulus, zero pad
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [RES_W-1:0] m_axis_tdata;   // power_result, zero pad

    int  fail_count;
    int  pending;
    int  quiet_cycles;
    bit  idle_on;
    bit  stall_on;

    modular_exponentiation #(
        .OPERAND_BITS(OPERAND_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    modexp_checker #(
        .OP_BITS(OPERAND_BITS)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_tvalid (s_axis_tvalid),
        .i_req_tready (s_axis_tready),
        .i_req_tdata  (s_axis_tdata),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock, starts low
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 8) begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(1, 4);
    endfunction

    // present one request beat; called and returns just after a falling edge
    task automatic send_request(t_operand base, t_operand exponent, t_operand modulus);
        if (idle_on && $urandom_range(0, 1) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_length()) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= REQ_W'({modulus, exponent, base});
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // result side: short ready bursts, random stalls when enabled
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            if (stall_on) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (gap_length() - 1) @(negedge i_clk);
            end
        end
    end

    // watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        t_operand rb;
        t_operand re;
        t_operand rm;
        int       phase;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_on       = 1'b0;
        stall_on      = 1'b0;
        quiet_cycles  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero exponent, modulus one, zero modulus, extremes, bit patterns
        send_request(31'd5, 31'd0, 31'd1);
        send_request(31'd0, 31'd0, OPERAND_MAX);
        send_request(31'd7, 31'd123, 31'd1);
        send_request(31'd0, 31'd5, 31'd13);
        send_request(31'd0, 31'd0, 31'd0);
        send_request(31'd9, 31'd4, 31'd0);
        stall_on = 1'b1;
        send_request(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX);
        send_request(OPERAND_MAX, 31'd1, 31'd1000);
        send_request(31'd2, 31'd30, OPERAND_MAX);
        send_request(31'd3, OPERAND_MAX, 31'd2);
        send_request(OPERAND_MAX, 31'd2, OPERAND_MAX - 31'd1);
        send_request(OPERAND_MAX - 31'd1, 31'd3, OPERAND_MAX);
        send_request(31'd1, OPERAND_MAX, 31'd7);
        send_request(31'd2, 31'd1, 31'd3);
        idle_on = 1'b1;
        send_request(31'd12345, 31'h5555_5555, 31'h2AAA_AAAB);
        send_request(31'h2AAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555);
        send_request(31'h5555_5555, 31'h5555_5555, 31'h2AAA_AAAA);
        send_request(OPERAND_MAX, OPERAND_MAX, 31'h4000_0000);
        send_request(31'h4000_0000, 31'h4000_0000, OPERAND_MAX - 31'd2);
        send_request(31'd0, OPERAND_MAX, 31'd1);

        // random: phases with result stalls only, both sides idling, input side only
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            phase    = (i / 40) % 3;
            idle_on  = (phase != 0);
            stall_on = (phase != 2);

            case ($urandom_range(0, 9))
                0, 1:    re = t_operand'($urandom_range(0, 15));
                2, 3, 4: re = t_operand'($urandom_range(0, 255));
                5:       re = t_operand'($urandom_range(0, 65535));
                default: re = t_operand'($urandom);
            endcase

            case ($urandom_range(0, 7))
                0:       rm = t_operand'($urandom_range(1, 16));
                1:       rm = t_operand'(1) << $urandom_range(0, OPERAND_BITS - 1);
                2:       rm = OPERAND_MAX - t_operand'($urandom_range(0, 64));
                default: rm = t_operand'($urandom);
            endcase

            case ($urandom_range(0, 7))
                0:       rb = t_operand'($urandom_range(0, 1));
                1:       rb = OPERAND_MAX;
                2:       rb = t_operand'($urandom_range(2, 1000));
                default: rb = t_operand'($urandom);
            endcase

            send_request(rb, re, rm);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for any stray beat
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
